### design/mcr_pkg.sv
// Package for the minimum cyclic rotation block.
// Holds field widths, request kinds, the default word length and the per-cell control struct.
// No dependencies.
`default_nettype none

package mcr_pkg;

   // Fixed field widths of the request and response channels
   localparam int WORD_W = 32;
   localparam int LEN_W  = 6;

   // Default number of bit cells in the rotation row
   localparam int MAX_BITS_DEF = 32;

   // Request kinds
   localparam logic KIND_PLAIN      = 1'b0;
   localparam logic KIND_COMPLEMENT = 1'b1;

   // Control broadcast to every cell of the row
   typedef struct packed {
      logic load;   // capture a new word
      logic step;   // rotate one place and update the running minimum
      logic take;   // current rotation is below the running minimum
   } mcr_ctl_type;

endpackage : mcr_pkg

`default_nettype wire

### design/mcr_cell.sv
// One bit cell of the rotation row: current-rotation bit, minimum bit, active bit.
// Also holds one slice of the rippled magnitude compare. Uses mcr_pkg.
`default_nettype none

module mcr_cell
   import mcr_pkg::*;
(
   input  wire logic        clock,
   input  wire mcr_ctl_type ctl,
   input  wire logic        load_bit,  // word bit, possibly inverted; masked inside the cell
   input  wire logic        load_act,  // bit lies inside the word length
   input  wire logic        nbr_in,    // current bit of the next lower cell
   input  wire logic        eq_in,     // higher bits of cur and best are equal
   input  wire logic        lt_in,     // higher bits already decide cur < best
   output logic             cur_out,
   output logic             best_out,
   output logic             eq_out,
   output logic             lt_out
);

   logic cur_ff,  cur_in;
   logic best_ff, best_in;
   logic act_ff,  act_in;

   // Next values: load a new word, or rotate and keep the smaller value
   always_comb begin
      cur_in  = cur_ff;
      best_in = best_ff;
      act_in  = act_ff;
      if (ctl.load) begin
         cur_in  = load_bit & load_act;
         best_in = load_bit & load_act;
         act_in  = load_act;
      end else if (ctl.step) begin
         cur_in = act_ff & nbr_in;
         if (ctl.take) begin
            best_in = cur_ff;
         end
      end
   end

   // Payload bits, no reset needed
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      best_ff <= best_in;
      act_ff  <= act_in;
   end

   // Compare slice, rippling from the top bit down
   assign eq_out   = eq_in & (cur_ff == best_ff);
   assign lt_out   = lt_in | (eq_in & ~cur_ff & best_ff);
   assign cur_out  = cur_ff;
   assign best_out = best_ff;

endmodule : mcr_cell

`default_nettype wire

### design/min_cyclic_rotation.sv
// Top level of the minimum cyclic rotation block: sequencer, row of bit cells,
// response register. Uses mcr_pkg and mcr_cell.
//
//   channel   ports                                        direction
//   req       req_valid req_stall req_kind req_word          in
//             req_length req_flag_in
//   rsp       rsp_valid rsp_stall rsp_canonical              out
//             rsp_length_out rsp_flag_out
//
// An item of effective length n (length saturated to MAX_BITS) steps through n
// rotations after its transfer; the row visits one rotation per cycle.
// The next request is taken in the cycle after the result is written.
// A result waiting on rsp_stall blocks the next request; the row
// holds its finished value until the response register frees.
// Reset is synchronous and clears only control state.
`default_nettype none

module min_cyclic_rotation
   import mcr_pkg::*;
#(
   parameter int MAX_BITS = MAX_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_kind,
   input  wire logic [WORD_W-1:0]   req_word,
   input  wire logic [LEN_W-1:0]    req_length,
   input  wire logic                req_flag_in,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [WORD_W-1:0]        rsp_canonical,
   output logic [LEN_W-1:0]         rsp_length_out,
   output logic                     rsp_flag_out
);

   localparam int W  = MAX_BITS;
   localparam int LW = $clog2(W + 1);           // holds 0..W
   localparam int IW = $clog2(W);               // indexes a cell
   localparam int CW = (W < WORD_W) ? W : WORD_W;
   localparam logic [LEN_W:0] MAX_LEN = (LEN_W + 1)'(W);

   typedef enum logic {S_IDLE, S_RUN} state_type;

   state_type          state_ff;
   logic [LW-1:0]      cnt_ff;
   logic [IW-1:0]      top_ff;
   logic [LW-1:0]      len_ff;
   logic               flag_ff;
   logic               rsp_valid_ff;
   logic [WORD_W-1:0]  rsp_canonical_ff;
   logic [LEN_W-1:0]   rsp_length_ff;
   logic               rsp_flag_ff;

   logic               req_xfer;
   logic               finish;
   logic [LEN_W:0]     len_sat;
   logic [LW-1:0]      len_req;
   logic [W-1:0]       mask_req;
   logic [W-1:0]       word_ext;
   logic [W-1:0]       load_vec;
   logic [W-1:0]       cur_vec;
   logic [W-1:0]       best_vec;
   logic [W-1:0]       nbr_vec;
   logic [W:0]         eq_chain;
   logic [W:0]         lt_chain;
   mcr_ctl_type        ctl;

   // Request side: length saturation, length mask, optional complement
   always_comb begin
      len_sat = ({1'b0, req_length} > MAX_LEN) ? MAX_LEN : {1'b0, req_length};
      len_req = LW'(len_sat);
      for (int i = 0; i < W; i++) begin
         mask_req[i] = (LW'(i) < len_req);
      end
      word_ext = W'(req_word[CW-1:0]);
      load_vec = (req_kind == KIND_COMPLEMENT) ? ~word_ext : word_ext;
   end

   // Sequencer controls
   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid & ~req_stall;
   assign finish    = (state_ff == S_RUN) && (cnt_ff == '0)
                      && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      ctl.load = req_xfer;
      ctl.step = (state_ff == S_RUN) && (cnt_ff != '0);
      ctl.take = lt_chain[0];
   end

   // Neighbor wiring: cell 0 wraps around from the top active cell
   always_comb begin
      nbr_vec[0] = cur_vec[top_ff];
      for (int i = 1; i < W; i++) begin
         nbr_vec[i] = cur_vec[i-1];
      end
   end

   assign eq_chain[W] = 1'b1;
   assign lt_chain[W] = 1'b0;

   // Row of bit cells
   for (genvar g = 0; g < W; g++) begin : g_cell
      mcr_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .load_bit (load_vec[g]),
         .load_act (mask_req[g]),
         .nbr_in   (nbr_vec[g]),
         .eq_in    (eq_chain[g+1]),
         .lt_in    (lt_chain[g+1]),
         .cur_out  (cur_vec[g]),
         .best_out (best_vec[g]),
         .eq_out   (eq_chain[g]),
         .lt_out   (lt_chain[g])
      );
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               if (finish) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // Payload registers
      if (req_xfer) begin
         cnt_ff  <= len_req;
         top_ff  <= IW'(len_req - LW'(1));
         len_ff  <= len_req;
         flag_ff <= req_flag_in;
      end else if (ctl.step) begin
         cnt_ff <= cnt_ff - LW'(1);
      end
      if (finish) begin
         rsp_canonical_ff <= WORD_W'(best_vec[CW-1:0]);
         rsp_length_ff    <= LEN_W'(len_ff);
         rsp_flag_ff      <= flag_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_canonical  = rsp_canonical_ff;
   assign rsp_length_out = rsp_length_ff;
   assign rsp_flag_out   = rsp_flag_ff;

   // Rotation preserves the number of ones, so the minimum keeps it too
   a_popcount: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> ($countones(cur_vec) == $countones(best_vec)))
      else $error("minimum and rotation differ in ones count");

   // Step counter counts down by one per rotation
   a_count: assert property (@(posedge clock) disable iff (reset)
      ctl.step |=> (cnt_ff == $past(cnt_ff) - LW'(1)))
      else $error("step counter did not decrement");

   // An equal rotation never replaces the minimum
   a_equal_hold: assert property (@(posedge clock) disable iff (reset)
      (ctl.step && eq_chain[0]) |=> $stable(best_vec))
      else $error("minimum changed on equal compare");

   // A finished item waits while the response register is occupied and stalled
   a_wait: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_RUN) && (cnt_ff == '0) && rsp_valid_ff && rsp_stall)
      |=> ((state_ff == S_RUN) && $stable(rsp_canonical_ff)))
      else $error("result overwritten while response stalled");

endmodule : min_cyclic_rotation

`default_nettype wire

### dv/tb_min_cyclic_rotation.sv
// Testbench for min_cyclic_rotation: drives requests, predicts the smallest rotation
// of each word in a scoreboard class and checks every response field by field.
// Depends on mcr_pkg and the min_cyclic_rotation RTL.
`timescale 1ns / 100ps

module tb_min_cyclic_rotation
   import mcr_pkg::*;
();

   localparam int RANDOM_ITEMS = 800;
   localparam int DRAIN_CYCLES = 2 * (MAX_BITS_DEF + 2);

   typedef struct {
      logic [WORD_W-1:0] canonical;
      logic [LEN_W-1:0]  length_out;
      logic              flag_out;
   } canon_result_type;

   // Predicts the canonical rotation and holds expectations in transfer order
   class canon_scoreboard_type;
      canon_result_type expected_q[$];
      int unsigned      mismatch_count;
      int unsigned      checked_count;

      function logic [WORD_W-1:0] min_rotation_of(logic [WORD_W-1:0] bits, int unsigned n);
         logic [63:0] mask;
         logic [63:0] cur;
         logic [63:0] best;
         if (n == 0) return '0;
         mask = (64'd1 << n) - 64'd1;
         cur  = {32'd0, bits} & mask;
         best = cur;
         // visit every rotation, keep the smallest
         for (int i = 1; i < n; i++) begin
            cur = ((cur << 1) | ((cur >> (n - 1)) & 64'd1)) & mask;
            if (cur < best) best = cur;
         end
         return best[WORD_W-1:0];
      endfunction

      function void note_request(logic kind_bit, logic [WORD_W-1:0] bits,
                                 logic [LEN_W-1:0] len, logic flag);
         int unsigned      n;
         logic [63:0]      mask;
         logic [63:0]      v;
         canon_result_type r;
         // lengths past the row saturate
         n    = (len > MAX_BITS_DEF) ? MAX_BITS_DEF : len;
         mask = (64'd1 << n) - 64'd1;
         v    = {32'd0, bits} & mask;
         if (kind_bit == KIND_COMPLEMENT) v = (v ^ mask) & mask;
         r.canonical  = min_rotation_of(v[WORD_W-1:0], n);
         r.length_out = n[LEN_W-1:0];
         r.flag_out   = flag;
         expected_q.push_back(r);
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         mismatch_count++;
      endtask

      task check_response(logic [WORD_W-1:0] canonical, logic [LEN_W-1:0] length_out,
                          logic flag_out);
         canon_result_type e;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("response %h/%0d with no request pending",
                                      canonical, length_out));
            return;
         end
         e = expected_q.pop_front();
         checked_count++;
         if (canonical !== e.canonical)
            report_mismatch($sformatf("canonical %h, expected %h", canonical, e.canonical));
         if (length_out !== e.length_out)
            report_mismatch($sformatf("length_out %0d, expected %0d",
                                      length_out, e.length_out));
         if (flag_out !== e.flag_out)
            report_mismatch($sformatf("flag_out %b, expected %b", flag_out, e.flag_out));
      endtask
   endclass

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_kind       = KIND_PLAIN;
   logic [WORD_W-1:0] req_word       = '0;
   logic [LEN_W-1:0]  req_length     = '0;
   logic              req_flag_in    = 1'b0;
   logic              rsp_stall      = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   logic [WORD_W-1:0] rsp_canonical;
   logic [LEN_W-1:0]  rsp_length_out;
   logic              rsp_flag_out;

   canon_scoreboard_type sb = new();
   int unsigned          send_idle_pct  = 6;
   int unsigned          recv_stall_pct = 64;
   int unsigned          sent_count     = 0;

   min_cyclic_rotation dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_word       (req_word),
      .req_length     (req_length),
      .req_flag_in    (req_flag_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_canonical  (rsp_canonical),
      .rsp_length_out (rsp_length_out),
      .rsp_flag_out   (rsp_flag_out)
   );

   always #5 clock = ~clock;

   // Receiver back-pressure, one decision per cycle
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_canonical, rsp_length_out, rsp_flag_out);
   end

   // Entered and left at a falling edge; valid stays high across back-to-back transfers
   task automatic send_request(logic k, logic [WORD_W-1:0] w, logic [LEN_W-1:0] len,
                               logic f);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= k;
      req_word    <= w;
      req_length  <= len;
      req_flag_in <= f;
      do @(posedge clock); while (req_stall);
      sb.note_request(k, w, len, f);
      sent_count++;
      @(negedge clock);
   endtask

   // Word shapes: dense, sparse, periodic, single bit, single zero, plain random
   function automatic logic [WORD_W-1:0] pick_word();
      logic [WORD_W-1:0] w;
      logic [7:0]        pat;
      int unsigned       period;
      case ($urandom_range(0, 5))
         0: w = $urandom | $urandom | $urandom;
         1: w = $urandom & $urandom & $urandom;
         2: begin
            period = $urandom_range(1, 8);
            pat    = 8'($urandom);
            w      = '0;
            for (int i = 0; i < WORD_W; i++) w[i] = pat[i % period];
         end
         3: w = 32'd1 << $urandom_range(0, WORD_W - 1);
         4: w = ~(32'd1 << $urandom_range(0, WORD_W - 1));
         default: w = $urandom;
      endcase
      return w;
   endfunction

   function automatic logic [LEN_W-1:0] pick_length();
      case ($urandom_range(0, 9))
         0: return LEN_W'($urandom_range(MAX_BITS_DEF + 1, 63));
         1: return LEN_W'($urandom_range(0, 2));
         2: return LEN_W'(MAX_BITS_DEF);
         default: return LEN_W'($urandom_range(1, MAX_BITS_DEF));
      endcase
   endfunction

   task automatic run_random(int unsigned count);
      repeat (count)
         send_request(1'($urandom_range(0, 1)), pick_word(), pick_length(),
                      1'($urandom_range(0, 1)));
   endtask

   // Run limit
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed: zero length, one bit, full width, saturation, high bits ignored
      send_request(KIND_PLAIN,      32'hFFFF_FFFF, 6'd0,  1'b1);
      send_request(KIND_COMPLEMENT, 32'h0000_0000, 6'd0,  1'b0);
      send_request(KIND_PLAIN,      32'h0000_0001, 6'd1,  1'b1);
      send_request(KIND_COMPLEMENT, 32'h0000_0000, 6'd1,  1'b0);
      send_request(KIND_COMPLEMENT, 32'h0000_0000, 6'd32, 1'b1);
      send_request(KIND_COMPLEMENT, 32'hFFFF_FFFF, 6'd32, 1'b0);
      send_request(KIND_PLAIN,      32'hFFFF_FFFF, 6'd32, 1'b1);
      send_request(KIND_PLAIN,      32'h0000_0000, 6'd32, 1'b0);
      send_request(KIND_PLAIN,      32'h8000_0000, 6'd32, 1'b1);
      send_request(KIND_PLAIN,      32'hAAAA_AAAA, 6'd32, 1'b0);
      send_request(KIND_COMPLEMENT, 32'hAAAA_AAAA, 6'd32, 1'b1);
      send_request(KIND_PLAIN,      32'h1234_5678, 6'd63, 1'b0);
      send_request(KIND_COMPLEMENT, 32'hDEAD_BEEF, 6'd33, 1'b1);
      send_request(KIND_PLAIN,      32'hFFFF_FFFE, 6'd2,  1'b0);
      send_request(KIND_PLAIN,      32'hFFFF_FFE5, 6'd5,  1'b1);
      send_request(KIND_COMPLEMENT, 32'hFFFF_FFFF, 6'd31, 1'b0);
      send_request(KIND_PLAIN,      32'h7FFF_FFFF, 6'd31, 1'b1);
      send_request(KIND_PLAIN,      32'h0000_00A5, 6'd8,  1'b0);
      send_request(KIND_COMPLEMENT, 32'hDEAD_BEEF, 6'd16, 1'b1);
      send_request(KIND_PLAIN,      32'h0000_8001, 6'd16, 1'b0);

      // Random, three flow-control mixes
      run_random(RANDOM_ITEMS / 3);
      send_idle_pct  = 64;
      recv_stall_pct = 6;
      run_random(RANDOM_ITEMS / 3);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
      req_valid <= 1'b0;

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.expected_q.size() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived", sb.expected_q.size()));

      $display("Run covered %0d requests (plain and complement, lengths 0 to 63) and %0d",
               sent_count, sb.checked_count);
      $display("responses under sender-heavy, receiver-heavy and unthrottled flow control.");
      if (sb.mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### filelist.f
design/mcr_pkg.sv
design/mcr_cell.sv
design/min_cyclic_rotation.sv
dv/tb_min_cyclic_rotation.sv
